[rtl/ipat_pkg.sv]
package ipat_pkg;

  localparam int unsigned NumBytes = 16;
  localparam int unsigned PosW     = 5;
  localparam int unsigned IdxW     = 4;

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegFamily = 1'b0;

  typedef logic [NumBytes-1:0][7:0] addr_bytes_t;

  // Decode one hex digit; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] h;
    h = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) h = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) h = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) h = 5'(c - 8'h37);
    return h;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

[rtl/ip_address_text_parser.sv]
// Parses IPv4 dotted-quad or IPv6 colon-hex text, one character per beat.
// Non-terminator characters are taken one per cycle while in_ready is
// high. A zero byte ends the string and gives one result beat. For an
// IPv6 string with a "::" gap the gap expander moves the tail one byte per
// cycle. The output register holds a result until taken, and input stalls
// while that result waits and out_ready is low, and while the gap is
// expanded. Writing address_family drops any partial string.
module ip_address_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_address_valid,
  output logic [63:0] out_address_high,
  output logic [63:0] out_address_low,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [ipat_pkg::CfgAddrW+1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {ST_RUN, ST_GAP, ST_OUT} state_t;

  state_t                 state_r, state_nxt;
  logic                   fam_r;
  ipat_pkg::addr_bytes_t  ab_r, ab_nxt;
  logic [4:0]             wp_r, wp_nxt, gp_r, gp_nxt;
  logic                   gseen_r, gseen_nxt;
  logic [15:0]            hv_r, hv_nxt;
  logic                   hasd_r, hasd_nxt;
  logic [7:0]             dv_r, dv_nxt;
  logic                   alld_r, alld_nxt;
  logic [2:0]             oc_r, oc_nxt;
  logic                   dot_r, dot_nxt;
  logic [1:0]             ph_r, ph_nxt;
  logic                   cag_r, cag_nxt;
  logic                   fail_r, fail_nxt;
  logic                   ov_r, ov_nxt;
  logic                   oa_r, oa_nxt;
  logic [63:0]            oh_r, oh_nxt, ol_r, ol_nxt;

  logic                   cfg_wr, acc;
  logic                   gm_start, gm_busy, gm_done;
  ipat_pkg::addr_bytes_t  gm_bytes;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[ipat_pkg::CfgAddrW+1:2] == ipat_pkg::RegFamily) &&
                  (cfg_paddr[1:0] == 2'b00);
  assign cfg_prdata = (cfg_paddr[ipat_pkg::CfgAddrW+1:2] == ipat_pkg::RegFamily)
                      ? {31'd0, fam_r} : 32'd0;

  assign in_ready = (state_r == ST_RUN) && (!ov_r || out_ready);
  assign acc = in_valid && in_ready;

  // Shared 8-bit decimal step: token*10 + digit
  logic [11:0] dec_n;
  logic [4:0]  hd;
  logic [19:0] hex_n;
  assign hd    = ipat_pkg::hex_digit(in_character);
  assign dec_n = 12'(dv_r) * 12'd10 + 12'(in_character - 8'h30);
  assign hex_n = {hv_r, hd[3:0]};

  ipat_gap_mover u_gap (
    .clk(clk), .rst_n(rst_n), .start(gm_start), .gap(gp_r[3:0]), .wpos(wp_r),
    .bytes_in(ab_r), .bytes_out(gm_bytes), .busy(gm_busy), .done(gm_done)
  );

  always_comb begin
    logic ok, dec_ok;
    logic [3:0] idx;
    logic fin;
    state_nxt = state_r;
    ab_nxt = ab_r; wp_nxt = wp_r; gp_nxt = gp_r; gseen_nxt = gseen_r;
    hv_nxt = hv_r; hasd_nxt = hasd_r; dv_nxt = dv_r; alld_nxt = alld_r;
    oc_nxt = oc_r; dot_nxt = dot_r; ph_nxt = ph_r; cag_nxt = cag_r;
    fail_nxt = fail_r;
    ov_nxt = ov_r; oa_nxt = oa_r; oh_nxt = oh_r; ol_nxt = ol_r;
    gm_start = 1'b0;
    ok = 1'b1; fin = 1'b0;
    dec_ok = 1'b0;
    idx = '0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      ST_RUN: begin
        if (acc && in_character != ipat_pkg::ChNul) begin
          if (!fail_r) begin
            // IPv6 phase handling
            if (fam_r && ph_r == 2'd0) begin
              ph_nxt = 2'd2;
            end else if (fam_r && ph_r == 2'd1) begin
              ph_nxt = 2'd2;
              if (in_character != ipat_pkg::ChColon) ok = 1'b0;
            end
            if (fam_r && ph_r == 2'd0 && in_character == ipat_pkg::ChColon) begin
              ph_nxt = 2'd1;
            end else if (ok) begin
              if (fam_r) cag_nxt = 1'b0;
              if (!fam_r || dot_r) begin
                // Dotted-quad character
                if (ipat_pkg::is_dec(in_character)) begin
                  if ((hasd_r && dv_r == 8'd0) || dec_n > 12'd255) ok = 1'b0;
                  else if (!hasd_r && oc_r >= 3'd4) ok = 1'b0;
                  else begin
                    dv_nxt = dec_n[7:0];
                    if (!hasd_r) begin
                      oc_nxt = oc_r + 3'd1;
                      hasd_nxt = 1'b1;
                    end
                    idx = wp_r[3:0] + 4'(oc_nxt) - 4'd1;
                    ab_nxt[idx] = dec_n[7:0];
                  end
                end else if (in_character == ipat_pkg::ChDot && hasd_r) begin
                  if (oc_r == 3'd4) ok = 1'b0;
                  else begin
                    dv_nxt = '0;
                    hasd_nxt = 1'b0;
                  end
                end else ok = 1'b0;
              end else if (!hd[4]) begin
                if (hex_n[19:16] != 4'd0) ok = 1'b0;
                else begin
                  hv_nxt = hex_n[15:0];
                  if (alld_r) begin
                    dec_ok = ipat_pkg::is_dec(in_character) &&
                             !(hasd_r && dv_r == 8'd0) && dec_n <= 12'd255;
                    if (dec_ok) dv_nxt = dec_n[7:0];
                    else alld_nxt = 1'b0;
                  end
                  hasd_nxt = 1'b1;
                end
              end else if (in_character == ipat_pkg::ChColon) begin
                dv_nxt = '0;
                alld_nxt = 1'b1;
                if (!hasd_r) begin
                  if (gseen_r) ok = 1'b0;
                  else begin
                    gseen_nxt = 1'b1;
                    gp_nxt = wp_r;
                  end
                end else if (wp_r > 5'd14) ok = 1'b0;
                else begin
                  ab_nxt[wp_r[3:0]] = hv_r[15:8];
                  ab_nxt[wp_r[3:0] + 4'd1] = hv_r[7:0];
                  wp_nxt = wp_r + 5'd2;
                  hasd_nxt = 1'b0;
                  hv_nxt = '0;
                  cag_nxt = 1'b1;
                end
              end else if (in_character == ipat_pkg::ChDot) begin
                if (!hasd_r || !alld_r || wp_r > 5'd12) ok = 1'b0;
                else begin
                  ab_nxt[wp_r[3:0]] = dv_r;
                  dot_nxt = 1'b1;
                  oc_nxt = 3'd1;
                  hasd_nxt = 1'b0;
                  dv_nxt = '0;
                  hv_nxt = '0;
                end
              end else ok = 1'b0;
            end
            if (!ok) fail_nxt = 1'b1;
          end
        end else if (acc) begin
          // Terminator: finish the string
          if (fail_r) ok = 1'b0;
          else if (!fam_r) ok = (oc_r == 3'd4);
          else begin
            if (ph_r == 2'd1 || cag_r) ok = 1'b0;
            else if (dot_r) begin
              if (oc_r != 3'd4) ok = 1'b0;
              else wp_nxt = wp_r + 5'd4;
            end else if (hasd_r) begin
              if (wp_r > 5'd14) ok = 1'b0;
              else begin
                ab_nxt[wp_r[3:0]] = hv_r[15:8];
                ab_nxt[wp_r[3:0] + 4'd1] = hv_r[7:0];
                wp_nxt = wp_r + 5'd2;
              end
            end
            if (ok && gseen_r) begin
              if (wp_nxt >= 5'd16 || gp_r > wp_nxt) ok = 1'b0;
            end else if (ok) ok = (wp_nxt == 5'd16);
          end
          if (ok && fam_r && gseen_r) begin
            // Commit tail bytes, then expand in the mover
            state_nxt = ST_GAP;
          end else begin
            fin = 1'b1;
          end
        end
      end
      ST_GAP: begin
        state_nxt = ST_OUT;
        gm_start = 1'b1;
      end
      ST_OUT: begin
        if (gm_done) begin
          ab_nxt = gm_bytes;
          fin = 1'b1;
          ok = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase

    if (fin) begin
      ov_nxt = 1'b1;
      oa_nxt = ok;
      oh_nxt = '0;
      ol_nxt = '0;
      if (ok && fam_r) begin
        oh_nxt = {ab_nxt[0], ab_nxt[1], ab_nxt[2], ab_nxt[3],
                  ab_nxt[4], ab_nxt[5], ab_nxt[6], ab_nxt[7]};
        ol_nxt = {ab_nxt[8], ab_nxt[9], ab_nxt[10], ab_nxt[11],
                  ab_nxt[12], ab_nxt[13], ab_nxt[14], ab_nxt[15]};
      end else if (ok) begin
        ol_nxt = {32'd0, ab_nxt[0], ab_nxt[1], ab_nxt[2], ab_nxt[3]};
      end
    end

    // Clear parse state at end of string or on a family write
    if (fin || cfg_wr) begin
      ab_nxt = '0; wp_nxt = '0; gp_nxt = '0; gseen_nxt = 1'b0;
      hv_nxt = '0; hasd_nxt = 1'b0; dv_nxt = '0; alld_nxt = 1'b1;
      oc_nxt = '0; dot_nxt = 1'b0; ph_nxt = '0; cag_nxt = 1'b0;
      fail_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      fam_r   <= 1'b0;
      ab_r    <= '0;
      wp_r    <= '0;
      gp_r    <= '0;
      gseen_r <= 1'b0;
      hv_r    <= '0;
      hasd_r  <= 1'b0;
      dv_r    <= '0;
      alld_r  <= 1'b1;
      oc_r    <= '0;
      dot_r   <= 1'b0;
      ph_r    <= '0;
      cag_r   <= 1'b0;
      fail_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) fam_r <= cfg_pwdata[0];
      ab_r    <= ab_nxt;
      wp_r    <= wp_nxt;
      gp_r    <= gp_nxt;
      gseen_r <= gseen_nxt;
      hv_r    <= hv_nxt;
      hasd_r  <= hasd_nxt;
      dv_r    <= dv_nxt;
      alld_r  <= alld_nxt;
      oc_r    <= oc_nxt;
      dot_r   <= dot_nxt;
      ph_r    <= ph_nxt;
      cag_r   <= cag_nxt;
      fail_r  <= fail_nxt;
      ov_r    <= ov_nxt;
    end
    oa_r <= oa_nxt;
    oh_r <= oh_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid         = ov_r;
  assign out_address_valid = oa_r;
  assign out_address_high  = oh_r;
  assign out_address_low   = ol_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(oh_r) && $stable(ol_r))
    else $error("result dropped");
  a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_RUN && !gm_busy) else $error("ready while busy");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !oa_r |-> oh_r == 64'd0 && ol_r == 64'd0)
    else $error("invalid result not zero");
`endif

endmodule

[rtl/ipat_gap_mover.sv]
// Expand a "::" gap: move the tail bytes to the end, one byte per cycle,
// from the last byte backward, zeroing the source after it is moved.
module ipat_gap_mover (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ipat_pkg::IdxW-1:0]    gap,
  input  logic [ipat_pkg::PosW-1:0]    wpos,
  input  ipat_pkg::addr_bytes_t        bytes_in,
  output ipat_pkg::addr_bytes_t        bytes_out,
  output logic                         busy,
  output logic                         done
);

  ipat_pkg::addr_bytes_t         buf_r, buf_nxt;
  logic [ipat_pkg::PosW-1:0]     left_r, left_nxt;
  logic [ipat_pkg::IdxW-1:0]     src_r, src_nxt, dst_r, dst_nxt;
  logic                          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    buf_nxt  = buf_r;
    left_nxt = left_r;
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      buf_nxt  = bytes_in;
      left_nxt = wpos - {1'b0, gap};
      src_nxt  = ipat_pkg::IdxW'(wpos - 5'd1);
      dst_nxt  = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (left_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // Move one byte and clear its old slot
        buf_nxt[src_r] = 8'h00;
        buf_nxt[dst_r] = buf_r[src_r];
        src_nxt  = src_r - 1'b1;
        dst_nxt  = dst_r - 1'b1;
        left_nxt = left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    buf_r  <= buf_nxt;
    left_r <= left_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
  end

  assign bytes_out = buf_r;
  assign busy      = busy_r;
  assign done      = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("start while busy");
  a_left_drops: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && left_r != '0 |=> left_r == $past(left_r) - 1'b1)
    else $error("count did not advance");
`endif

endmodule
